FILE: rtl/tst_pkg.sv
`timescale 1ns / 1ps

package tst_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned LSN_W         = 64;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned STATUS_W      = 3;

  // scan counter value once every slot has been addressed
  localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(TABLE_ENTRIES);

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_OPEN   = 2'd0,
    OP_COMMIT = 2'd1,
    OP_ABORT  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ZEROID   = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  // one transaction record as held in the record ram
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LSN_W-1:0] snapshot;
    logic             done;
    logic [LSN_W-1:0] cmt_pos;
  } rec_t;

  // outcome of a table scan, handed from the scanner to the update logic
  typedef struct packed {
    logic             busy;
    logic             fin;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    rec_t             rec;
  } scan_t;

endpackage

FILE: rtl/tst_if.sv
`timescale 1ns / 1ps

// request channel
interface tst_req_if;
  logic                          valid;
  logic                          ready;
  logic [tst_pkg::OP_W-1:0]      op;
  logic [tst_pkg::ID_W-1:0]      txn_id;
  logic [tst_pkg::LSN_W-1:0]     lsn;

  modport source (output valid, op, txn_id, lsn, input ready);
  modport sink   (input valid, op, txn_id, lsn, output ready);
endinterface

// response channel
interface tst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tst_pkg::STATUS_W-1:0]  status;
  logic                          hit_committed;
  logic [tst_pkg::LSN_W-1:0]     hit_snapshot_lsn;
  logic [tst_pkg::LSN_W-1:0]     hit_commit_lsn;
  logic [tst_pkg::LSN_W-1:0]     max_commit_lsn;
  logic [tst_pkg::CNT_W-1:0]     used_entries;

  modport source (output valid, status, hit_committed, hit_snapshot_lsn, hit_commit_lsn,
                  max_commit_lsn, used_entries, input ready);
  modport sink   (input valid, status, hit_committed, hit_snapshot_lsn, hit_commit_lsn,
                  max_commit_lsn, used_entries, output ready);
endinterface

FILE: rtl/tst_ram.sv
`timescale 1ns / 1ps

module tst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/tst_scan.sv
`timescale 1ns / 1ps

module tst_scan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tst_pkg::ID_W-1:0]            key_i,
  input  logic [tst_pkg::TABLE_ENTRIES-1:0]   valid_i,
  input  tst_pkg::rec_t                       rdata_i,
  output logic [tst_pkg::IDX_W-1:0]           raddr_o,
  output tst_pkg::scan_t                      scan_o
);

  logic                       busy_q, busy_d;
  logic [tst_pkg::IDX_W:0]    cnt_q, cnt_d;
  logic                       rd_vld_q, rd_vld_d;
  logic                       hit_q, hit_d;
  logic                       free_q, free_d;
  logic [tst_pkg::IDX_W-1:0]  rd_idx_q;
  logic [tst_pkg::IDX_W-1:0]  hit_idx_q;
  logic [tst_pkg::IDX_W-1:0]  free_idx_q;
  tst_pkg::rec_t              rec_q;

  logic issue;
  logic slot_match;
  logic slot_free;
  logic fin;

  // one slot addressed per cycle, its record compared in the next cycle
  always_comb begin
    issue      = busy_q && (cnt_q != tst_pkg::SCAN_END);
    raddr_o    = cnt_q[tst_pkg::IDX_W-1:0];
    slot_match = rd_vld_q && valid_i[rd_idx_q] && (rdata_i.id == key_i);
    slot_free  = rd_vld_q && !valid_i[rd_idx_q];
    fin        = busy_q && !issue && !rd_vld_q;
  end

  // scan control
  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    rd_vld_d = issue;
    hit_d    = hit_q;
    free_d   = free_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      rd_vld_d = 1'b0;
      hit_d    = 1'b0;
      free_d   = 1'b0;
    end else begin
      if (issue) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (fin) begin
        busy_d = 1'b0;
      end
      if (slot_match) begin
        hit_d = 1'b1;
      end
      if (slot_free) begin
        free_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
    end
  end

  // captured slot indexes and the matching record, lowest index wins
  always_ff @(posedge clk_i) begin
    rd_idx_q <= raddr_o;
    if (slot_match && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      rec_q     <= rdata_i;
    end
    if (slot_free && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  always_comb begin
    scan_o.busy     = busy_q;
    scan_o.fin      = fin;
    scan_o.hit      = hit_q;
    scan_o.hit_idx  = hit_idx_q;
    scan_o.free     = free_q;
    scan_o.free_idx = free_idx_q;
    scan_o.rec      = rec_q;
  end

endmodule

FILE: rtl/transaction_status_table.sv
`timescale 1ns / 1ps
// a request is accepted only in idle, so the block takes no new request before it has
// finished the last; each request scans the record ram through its single read port,
//   one slot a cycle, then compares the last slot, finishes the scan, updates (held
//   while the response register is full and not taken) and returns to idle
// reset: asynchronous, active low; valid marks, record count and commit maximum
//   clear at once, record contents stay undefined until written

module transaction_status_table (
  input  logic     clk_i,
  input  logic     rst_ni,
  tst_req_if.sink  req_i,
  tst_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e                              state_q, state_d;
  tst_pkg::op_e                        op_q;
  logic [tst_pkg::ID_W-1:0]            id_q;
  logic [tst_pkg::LSN_W-1:0]           lsn_q;
  logic [tst_pkg::TABLE_ENTRIES-1:0]   valid_q, valid_d;
  logic [tst_pkg::CNT_W-1:0]           live_q, live_d;
  logic [tst_pkg::LSN_W-1:0]           max_q, max_d;

  logic                                out_valid_q, out_valid_d;
  logic [tst_pkg::STATUS_W-1:0]        out_status_q;
  logic                                out_done_q;
  logic [tst_pkg::LSN_W-1:0]           out_snap_q;
  logic [tst_pkg::LSN_W-1:0]           out_commit_q;
  logic [tst_pkg::LSN_W-1:0]           out_max_q;
  logic [tst_pkg::CNT_W-1:0]           out_used_q;

  tst_pkg::scan_t                      scan_st;
  tst_pkg::rec_t                       ram_rdata;
  logic [tst_pkg::IDX_W-1:0]           ram_raddr;
  logic                                ram_we;
  logic [tst_pkg::IDX_W-1:0]           ram_waddr;

  logic                                req_fire;
  logic                                out_free;
  logic                                upd;
  tst_pkg::status_e                    status;
  tst_pkg::rec_t                       rec_new;
  logic                                show;
  logic                                wr_rec;
  logic                                set_valid;
  logic                                clr_valid;
  logic [tst_pkg::LSN_W-1:0]           max_new;

  // record store and the slot scanner
  tst_ram #(
    .WIDTH ($bits(tst_pkg::rec_t)),
    .DEPTH (tst_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rec_new),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tst_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_fire),
    .key_i   (id_q),
    .valid_i (valid_q),
    .rdata_i (ram_rdata),
    .raddr_o (ram_raddr),
    .scan_o  (scan_st)
  );

  // handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign upd         = (state_q == S_UPDATE) && out_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_st.fin) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // operation outcome from the scan result
  always_comb begin
    status    = tst_pkg::ST_NOTFOUND;
    rec_new   = scan_st.rec;
    show      = 1'b0;
    wr_rec    = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    ram_waddr = scan_st.hit_idx;
    max_new   = max_q;
    unique case (op_q)
      tst_pkg::OP_OPEN, tst_pkg::OP_COMMIT: begin
        if (id_q == '0) begin
          status = tst_pkg::ST_ZEROID;
        end else begin
          if ((op_q == tst_pkg::OP_COMMIT) && (lsn_q > max_q)) begin
            max_new = lsn_q;
          end
          if (scan_st.hit) begin
            status = tst_pkg::ST_UPDATED;
          end else if (scan_st.free) begin
            status           = tst_pkg::ST_INSERTED;
            ram_waddr        = scan_st.free_idx;
            set_valid        = 1'b1;
            rec_new.id       = id_q;
            rec_new.snapshot = '0;
            rec_new.done     = 1'b0;
            rec_new.cmt_pos  = '0;
          end else begin
            status = tst_pkg::ST_FULL;
          end
          if (op_q == tst_pkg::OP_OPEN) begin
            rec_new.snapshot = lsn_q;
            rec_new.done     = 1'b0;
          end else begin
            rec_new.done    = 1'b1;
            rec_new.cmt_pos = lsn_q;
          end
          wr_rec = scan_st.hit || scan_st.free;
          show   = scan_st.hit || scan_st.free;
        end
      end
      tst_pkg::OP_ABORT: begin
        if (scan_st.hit) begin
          status    = tst_pkg::ST_REMOVED;
          clr_valid = 1'b1;
        end
      end
      tst_pkg::OP_LOOKUP: begin
        if (scan_st.hit) begin
          status = tst_pkg::ST_FOUND;
          show   = 1'b1;
        end
      end
      default: status = tst_pkg::ST_NOTFOUND;
    endcase
  end

  assign ram_we = upd && wr_rec;

  // table bookkeeping
  always_comb begin
    valid_d = valid_q;
    live_d  = live_q;
    max_d   = max_q;
    if (upd) begin
      max_d = max_new;
      if (set_valid) begin
        valid_d[scan_st.free_idx] = 1'b1;
        live_d                    = live_q + 1'b1;
      end
      if (clr_valid) begin
        valid_d[scan_st.hit_idx] = 1'b0;
        live_d                   = live_q - 1'b1;
      end
    end
  end

  // response register
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (upd) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      live_q      <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      live_q      <= live_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= tst_pkg::op_e'(req_i.op);
      id_q  <= req_i.txn_id;
      lsn_q <= req_i.lsn;
    end
    if (upd) begin
      out_status_q <= status;
      out_done_q   <= show ? rec_new.done : 1'b0;
      out_snap_q   <= show ? rec_new.snapshot : '0;
      out_commit_q <= show ? rec_new.cmt_pos : '0;
      out_max_q    <= max_new;
      out_used_q   <= live_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.hit_committed    = out_done_q;
  assign rsp_o.hit_snapshot_lsn = out_snap_q;
  assign rsp_o.hit_commit_lsn   = out_commit_q;
  assign rsp_o.max_commit_lsn   = out_max_q;
  assign rsp_o.used_entries     = out_used_q;

`ifndef ASSERT_OFF
  // record count tracks the valid marks
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q == tst_pkg::CNT_W'($countones(valid_q)))
    else $error("record count differs from valid marks");

  // an accepted request starts a scan
  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> scan_st.busy)
    else $error("scan not started after request");

  // the record ram is never written while the scan reads it
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && scan_st.busy))
    else $error("record write during scan");

  // the commit maximum never falls
  a_max_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> max_q >= $past(max_q))
    else $error("commit maximum decreased");
`endif

endmodule
